// ===== src/srt_pkg.sv =====
// Shared constants, codes and types for the retransmit tracker.
// No dependencies; imported by the top level and by srt_mod.
`default_nettype none
package srt_pkg;
   localparam int RING_DEPTH  = 32;
   localparam int IDX_W       = $clog2(RING_DEPTH);
   localparam int CNT_W       = $clog2(RING_DEPTH + 1);
   // modulus is 15 * 2^MOD_LOW_W; the reduction unit folds nibbles mod 15
   localparam int MOD_LOW_W   = 11;
   localparam int SEQ_MODULUS = 15 << MOD_LOW_W;
   localparam int SMOD_W      = 16;
   localparam int WORD_W      = 32;
   localparam int ADDR_W      = 4;

   localparam logic [2:0] FUNC_START   = 3'd0;
   localparam logic [2:0] FUNC_INSERT  = 3'd1;
   localparam logic [2:0] FUNC_ACK     = 3'd2;
   localparam logic [2:0] FUNC_SCAN    = 3'd3;
   localparam logic [2:0] FUNC_WINDOW  = 3'd4;
   localparam logic [2:0] FUNC_RESTAMP = 3'd5;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_DUP     = 3'd1;
   localparam logic [2:0] ST_FAST    = 3'd2;
   localparam logic [2:0] ST_NOMATCH = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;

   localparam logic [1:0] REG_CWND   = 2'd0;
   localparam logic [1:0] REG_RTO    = 2'd1;
   localparam logic [1:0] REG_SRTT   = 2'd2;
   localparam logic [1:0] REG_DEVRTT = 2'd3;

   typedef struct packed {
      logic [WORD_W-1:0] seg_start;
      logic [WORD_W-1:0] seg_end;
      logic [WORD_W-1:0] sent;
      logic [SMOD_W-1:0] start_mod;
      logic [SMOD_W-1:0] end_mod;
      logic [1:0]        dups;
   } entry_type;
endpackage
`default_nettype wire

// ===== src/sender_retransmit_tracker.sv =====
// Top level: sequencer, ring bookkeeping, RTT estimator and CSR port.
// Uses srt_pkg, srt_ram (entry store) and srt_mod (shared modulo unit).
//
//   channel | ports                   | role
//   req     | req_valid / req_stall   | one request: func plus operands
//   rsp     | rsp_valid / rsp_stall   | one result per request
//   csr     | psel penable pwrite ... | APB-style register access
//
// Start, full insert, empty-ring requests and unused codes answer from idle; insert
// runs two modulo passes (start, then end), then writes the entry. Ack, scan, restamp:
// each ring entry visited is read, then compared (registered RAM read); a matched ack
// adds the RTT update, an unmatched ack walks the ring twice. Window check reads the
// last entry, then the first. Reset clears control state; entry RAM is don't-care
// until written. req_stall is high while a request is in work or a result waits.
`default_nettype none
module sender_retransmit_tracker import srt_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [2:0]        req_func,
   input  wire logic [WORD_W-1:0] req_seg_start,
   input  wire logic [WORD_W-1:0] req_seg_end,
   input  wire logic [15:0]       req_ack_number,
   input  wire logic [15:0]       req_short_seq,
   input  wire logic [WORD_W-1:0] req_now_time,
   input  wire logic [15:0]       req_data_size,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [2:0]             rsp_status,
   output logic                   rsp_hit,
   output logic [WORD_W-1:0]      rsp_seq_out,
   output logic [WORD_W-1:0]      rsp_rto_now,
   output logic                   rsp_ring_empty,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [WORD_W-1:0] pwdata,
   output logic [WORD_W-1:0]      prdata,
   output logic                   pready
);
   typedef enum logic [2:0] {
      S_IDLE, S_MODS, S_MODE, S_RD, S_CMP, S_RTT1, S_RTT2
   } state_type;

   state_type         state_ff, state_in;
   logic [2:0]        func_ff, func_in;
   logic [WORD_W-1:0] start_ff, start_in, end_ff, end_in, now_ff, now_in;
   logic [15:0]       ackn_ff, ackn_in, sseq_ff, sseq_in, dsize_ff, dsize_in;
   logic [SMOD_W-1:0] smod_ff, smod_in;
   logic [CNT_W-1:0]  idx_ff, idx_in, count_ff, count_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic              phase_ff, phase_in;
   logic [WORD_W-1:0] scratch_ff, scratch_in;
   logic [WORD_W-1:0] srtt_ff, srtt_in, dev_ff, dev_in, rto_ff, rto_in;
   logic [2:0]        status_ff, status_in;
   logic              hit_ff, hit_in, rvalid_ff, rvalid_in;
   logic [WORD_W-1:0] seq_ff, seq_in;
   logic [15:0]       cwnd_ff;
   logic [WORD_W-1:0] irto_ff, isrtt_ff, idev_ff;

   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr, slot;
   entry_type         ram_wdata, ram_rdata, e;
   logic              mod_go, mod_done;
   logic [WORD_W-1:0] mod_din;
   logic [SMOD_W-1:0] mod_res;
   logic              accept, csr_wr;
   logic [2:0]        dnext;
   logic [WORD_W-1:0] span;
   logic signed [33:0] diff, mag, dm;
   logic [34:0]       rto_sum;

   assign slot      = head_ff + idx_ff[IDX_W-1:0];
   assign req_stall = (state_ff != S_IDLE) || rvalid_ff;
   assign accept    = req_valid && !req_stall;
   assign csr_wr    = psel && penable && pwrite;
   assign pready    = 1'b1;

   srt_ram #(.WIDTH($bits(entry_type)), .DEPTH(RING_DEPTH)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (slot),
      .rdata (ram_rdata)
   );

   srt_mod u_mod (
      .clock  (clock),
      .reset  (reset),
      .go     (mod_go),
      .din    (mod_din),
      .done   (mod_done),
      .result (mod_res)
   );

   always_comb begin
      case (paddr[3:2])
         REG_CWND:   prdata = {16'b0, cwnd_ff};
         REG_RTO:    prdata = irto_ff;
         REG_SRTT:   prdata = isrtt_ff;
         REG_DEVRTT: prdata = idev_ff;
         default:    prdata = '0;
      endcase
   end

   always_comb begin
      state_in = state_ff;   func_in = func_ff;     start_in = start_ff;
      end_in = end_ff;       now_in = now_ff;       ackn_in = ackn_ff;
      sseq_in = sseq_ff;     dsize_in = dsize_ff;   smod_in = smod_ff;
      idx_in = idx_ff;       count_in = count_ff;   head_in = head_ff;
      phase_in = phase_ff;   scratch_in = scratch_ff;
      srtt_in = srtt_ff;     dev_in = dev_ff;       rto_in = rto_ff;
      status_in = status_ff; hit_in = hit_ff;       seq_in = seq_ff;
      rvalid_in = rvalid_ff && rsp_stall;
      ram_we = 1'b0;
      ram_waddr = slot;
      e = ram_rdata;
      ram_wdata = e;
      mod_go = 1'b0;
      mod_din = end_ff;
      dnext = {1'b0, e.dups} + 3'd1;
      span = scratch_ff - e.seg_start + {16'b0, dsize_ff};
      diff = $signed({2'b0, scratch_ff}) - $signed({2'b0, srtt_ff});
      mag = diff[33] ? -diff : diff;
      dm = mag - $signed({2'b0, dev_ff});
      rto_sum = {3'b0, srtt_ff} + {1'b0, dev_ff, 2'b0};

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in = req_func;   start_in = req_seg_start; end_in = req_seg_end;
               now_in = req_now_time; ackn_in = req_ack_number;
               sseq_in = req_short_seq; dsize_in = req_data_size;
               idx_in = '0; phase_in = 1'b0;
               status_in = ST_OK; hit_in = 1'b0; seq_in = '0;
               case (req_func)
                  FUNC_START: begin
                     head_in = '0; count_in = '0;
                     rto_in = irto_ff; srtt_in = isrtt_ff; dev_in = idev_ff;
                     rvalid_in = 1'b1;
                  end
                  FUNC_INSERT: begin
                     if (count_ff >= CNT_W'(RING_DEPTH)) begin
                        status_in = ST_FULL;
                        rvalid_in = 1'b1;
                     end else begin
                        mod_go = 1'b1;
                        mod_din = req_seg_start;
                        state_in = S_MODS;
                     end
                  end
                  FUNC_ACK, FUNC_SCAN, FUNC_RESTAMP: begin
                     if (count_ff == '0) begin
                        status_in = (req_func == FUNC_SCAN) ? ST_OK : ST_NOMATCH;
                        rvalid_in = 1'b1;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  FUNC_WINDOW: begin
                     if (count_ff == '0) begin
                        hit_in = req_data_size <= cwnd_ff;
                        rvalid_in = 1'b1;
                     end else begin
                        idx_in = count_ff - CNT_W'(1);
                        state_in = S_RD;
                     end
                  end
                  default: rvalid_in = 1'b1;
               endcase
            end
         end
         S_MODS: begin
            if (mod_done) begin
               smod_in = mod_res;
               mod_go = 1'b1;
               state_in = S_MODE;
            end
         end
         S_MODE: begin
            if (mod_done) begin
               ram_we = 1'b1;
               ram_waddr = head_ff + count_ff[IDX_W-1:0];
               ram_wdata = '{seg_start: start_ff, seg_end: end_ff, sent: now_ff,
                             start_mod: smod_ff, end_mod: mod_res, dups: 2'b0};
               count_in = count_ff + CNT_W'(1);
               rvalid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_RD: state_in = S_CMP;
         S_CMP: begin
            state_in = S_RD;
            if (func_ff == FUNC_WINDOW) begin
               if (!phase_ff) begin
                  scratch_in = e.seg_end;
                  idx_in = '0;
                  phase_in = 1'b1;
               end else begin
                  hit_in = span <= {16'b0, cwnd_ff};
                  rvalid_in = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (func_ff == FUNC_ACK && !phase_ff && e.end_mod == ackn_ff) begin
               scratch_in = now_ff - e.sent;
               state_in = S_RTT1;
            end else if (func_ff == FUNC_ACK && phase_ff && e.start_mod == ackn_ff) begin
               ram_we = 1'b1;
               ram_wdata.dups = (dnext >= 3'd3) ? 2'b0 : dnext[1:0];
               status_in = (dnext >= 3'd3) ? ST_FAST : ST_DUP;
               rvalid_in = 1'b1;
               state_in = S_IDLE;
            end else if (func_ff == FUNC_SCAN && (now_ff - e.sent) >= rto_ff) begin
               hit_in = 1'b1;
               seq_in = e.seg_start;
               rvalid_in = 1'b1;
               state_in = S_IDLE;
            end else if (func_ff == FUNC_RESTAMP && e.start_mod == sseq_ff) begin
               ram_we = 1'b1;
               ram_wdata.sent = now_ff;
               hit_in = 1'b1;
               rvalid_in = 1'b1;
               state_in = S_IDLE;
            end else if (idx_ff + CNT_W'(1) == count_ff) begin
               // end of ring: ack falls back to the duplicate pass
               if (func_ff == FUNC_ACK && !phase_ff) begin
                  phase_in = 1'b1;
                  idx_in = '0;
               end else begin
                  status_in = (func_ff == FUNC_SCAN) ? ST_OK : ST_NOMATCH;
                  rvalid_in = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         S_RTT1: begin
            srtt_in = 32'($signed({2'b0, srtt_ff}) + (diff >>> 3));
            dev_in  = 32'($signed({2'b0, dev_ff}) + (dm >>> 2));
            state_in = S_RTT2;
         end
         S_RTT2: begin
            rto_in = (rto_sum[34:32] != 3'b0) ? '1 : rto_sum[31:0];
            head_in = head_ff + idx_ff[IDX_W-1:0] + IDX_W'(1);
            count_in = count_ff - idx_ff - CNT_W'(1);
            rvalid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rvalid_ff <= 1'b0;
         count_ff <= '0;
         head_ff <= '0;
         srtt_ff <= '0;
         dev_ff <= '0;
         rto_ff <= '0;
         cwnd_ff <= 16'd1024;
         irto_ff <= 32'd500000;
         isrtt_ff <= '0;
         idev_ff <= '0;
      end else begin
         state_ff <= state_in;
         rvalid_ff <= rvalid_in;
         count_ff <= count_in;
         head_ff <= head_in;
         srtt_ff <= srtt_in;
         dev_ff <= dev_in;
         rto_ff <= rto_in;
         if (csr_wr) begin
            case (paddr[3:2])
               REG_CWND:   cwnd_ff <= pwdata[15:0];
               REG_RTO:    irto_ff <= pwdata;
               REG_SRTT:   isrtt_ff <= pwdata;
               REG_DEVRTT: idev_ff <= pwdata;
               default:    cwnd_ff <= cwnd_ff;
            endcase
         end
      end
      func_ff <= func_in;   start_ff <= start_in; end_ff <= end_in;
      now_ff <= now_in;     ackn_ff <= ackn_in;   sseq_ff <= sseq_in;
      dsize_ff <= dsize_in; smod_ff <= smod_in;   idx_ff <= idx_in;
      phase_ff <= phase_in; scratch_ff <= scratch_in;
      status_ff <= status_in; hit_ff <= hit_in;   seq_ff <= seq_in;
   end

   assign rsp_valid      = rvalid_ff;
   assign rsp_status     = status_ff;
   assign rsp_hit        = hit_ff;
   assign rsp_seq_out    = seq_ff;
   assign rsp_rto_now    = rto_ff;
   assign rsp_ring_empty = (count_ff == '0);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RING_DEPTH))
      else $error("ring count beyond depth");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (req_stall && !rvalid_ff))
      else $error("result shown while sequencer busy");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> (idx_ff < count_ff))
      else $error("ring walk past last entry");
endmodule
`default_nettype wire

// ===== src/srt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module srt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== src/srt_mod.sv =====
// Reduction of a 32-bit sequence number modulo SEQ_MODULUS (15 * 2^MOD_LOW_W).
// Uses srt_pkg; each value takes two steps: nibble sum, then fold and subtract.
`default_nettype none
module srt_mod import srt_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              go,
   input  wire logic [WORD_W-1:0] din,
   output logic                   done,
   output logic [SMOD_W-1:0]      result
);
   // upper part q = din >> MOD_LOW_W; 16 = 1 mod 15, so q mod 15 = nibble sum mod 15
   logic [23:0]          q;
   logic [6:0]           nsum;
   logic [4:0]           fold;
   logic [6:0]           sum_ff, sum_in;
   logic [MOD_LOW_W-1:0] low_ff, low_in;
   logic [SMOD_W-1:0]    rem_ff, rem_in;
   logic                 busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      q    = 24'(din[WORD_W-1:MOD_LOW_W]);
      nsum = 7'(q[3:0]) + 7'(q[7:4]) + 7'(q[11:8]) + 7'(q[15:12])
           + 7'(q[19:16]) + 7'(q[23:20]);
      fold = 5'(sum_ff[6:4]) + 5'(sum_ff[3:0]);
      sum_in  = sum_ff;
      low_in  = low_ff;
      rem_in  = rem_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (go) begin
         sum_in  = nsum;
         low_in  = din[MOD_LOW_W-1:0];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = {1'b0, (fold >= 5'd15) ? 4'(fold - 5'd15) : fold[3:0], low_ff};
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      sum_ff <= sum_in;
      low_ff <= low_in;
      rem_ff <= rem_in;
   end

   assign done   = done_ff;
   assign result = rem_ff;
endmodule
`default_nettype wire
